@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the top level file that checks the transform unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent at every rising clock edge outside reset.
`define HPT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The condition never holds at a rising clock edge outside reset.
`define HPT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/hpt_pkg.sv @@
// Package with the constants and types of the homogeneous point transform unit.
`timescale 1ns / 1ps

package hpt_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int NUM_REGS   = 8;
  localparam int REG_SEL_W  = $clog2(NUM_REGS);
  localparam int CFG_IDX_W  = 4;
  localparam int REG_W      = 64;
  localparam int COORD_W    = 32;
  localparam int ACC_W      = 64;

  typedef logic [NUM_REGS-1:0][REG_W-1:0] mat_t;

  // One transformed vertex waiting for its perspective divide.
  typedef struct packed {
    logic                       point;
    logic                       w_zero;
    logic [3:0][ACC_W-1:0]      acc;
  } hpt_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic       point;
    logic       w_zero;
    logic [2:0] neg;
  } side_t;

endpackage

@@ hw/rtl/hpt_if.sv @@
// Channel interfaces of the homogeneous point transform unit.
`timescale 1ns / 1ps

interface hpt_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic signed [31:0] x_in;
  logic signed [31:0] y_in;
  logic signed [31:0] z_in;
  modport source (output valid, mode, x_in, y_in, z_in, input ready);
  modport sink (input valid, mode, x_in, y_in, z_in, output ready);
endinterface

interface hpt_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] x_out;
  logic signed [31:0] y_out;
  logic signed [31:0] z_out;
  logic        w_zero;
  logic        saturated;
  modport source (output valid, x_out, y_out, z_out, w_zero, saturated, input ready);
  modport sink (input valid, x_out, y_out, z_out, w_zero, saturated, output ready);
endinterface

interface hpt_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/hpt_div_lane.sv @@
// Pipelined restoring divider lane giving a saturation-ready fixed point quotient.
`timescale 1ns / 1ps

module hpt_div_lane #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [hpt_pkg::ACC_W-1:0]      nx,
  input  logic [hpt_pkg::ACC_W-1:0]      nw,
  output logic [hpt_pkg::COORD_W-1:0]    q,
  output logic                           ovf
);

  localparam int AW = hpt_pkg::ACC_W;
  localparam int QW = hpt_pkg::COORD_W;
  localparam int NW = AW + FRAC_BITS;

  logic [AW-1:0] rem_r [QW+1];
  logic [AW-1:0] nw_r  [QW+1];
  logic [QW-1:0] nl_r  [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic          ovf_r [QW+1];

  logic [NW-1:0] nsh;
  logic [AW-1:0] rem0;

  assign nsh  = {nx, {FRAC_BITS{1'b0}}};
  assign rem0 = AW'(nsh[NW-1:QW]);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= rem0;
      nw_r[0]  <= nw;
      nl_r[0]  <= nsh[QW-1:0];
      q_r[0]   <= '0;
      ovf_r[0] <= (rem0 >= nw);
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [AW:0]   sh;
    logic          ge;
    logic [AW:0]   diff;

    assign sh   = {rem_r[s], nl_r[s][QW-1]};
    assign ge   = (sh >= {1'b0, nw_r[s]});
    assign diff = sh - {1'b0, nw_r[s]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= ge ? diff[AW-1:0] : sh[AW-1:0];
        nw_r[s+1]  <= nw_r[s];
        nl_r[s+1]  <= {nl_r[s][QW-2:0], 1'b0};
        q_r[s+1]   <= {q_r[s][QW-2:0], ge};
        ovf_r[s+1] <= ovf_r[s];
      end
    end
  end

  assign q   = q_r[QW];
  assign ovf = ovf_r[QW];

endmodule

@@ hw/rtl/hpt_fifo.sv @@
// Short queue of transformed vertices between the front and the back part.
`timescale 1ns / 1ps

module hpt_fifo #(
  parameter int DEPTH = hpt_pkg::FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hpt_pkg::hpt_item_t wdata,
  input  logic               pop,
  output hpt_pkg::hpt_item_t rdata,
  output hpt_pkg::q_stat_t   stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  hpt_pkg::hpt_item_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

@@ hw/rtl/hpt_front.sv @@
// Front part: matrix registers, vertex intake, matrix multiply and w classification.
`timescale 1ns / 1ps

module hpt_front #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  hpt_in_if.sink             in_if,
  hpt_cfg_if.sink            cfg_if,
  input  logic               q_full,
  output logic               push,
  output hpt_pkg::hpt_item_t item
);

  localparam int AW = hpt_pkg::ACC_W;
  localparam int SW = 2 * hpt_pkg::COORD_W + 2;
  localparam logic [hpt_pkg::REG_W-1:0] ONE_LO = hpt_pkg::REG_W'(64'd1 << FRAC_BITS);
  localparam logic [hpt_pkg::REG_W-1:0] ONE_HI = hpt_pkg::REG_W'(64'd1 << (FRAC_BITS + 32));
  localparam logic [hpt_pkg::REG_W-1:0] ZERO_W = hpt_pkg::REG_W'(0);
  localparam hpt_pkg::mat_t MAT_RST = {ONE_HI, ZERO_W, ONE_LO, ZERO_W,
                                       ZERO_W, ONE_HI, ZERO_W, ONE_LO};

  hpt_pkg::mat_t mat_r;
  logic          en;
  logic          s1_v_r, s2_v_r;
  logic          s1_point_r, s2_point_r;

  logic signed [31:0] m   [4][4];
  logic signed [31:0] vec [3];
  logic signed [63:0] p_r [4][3];
  logic signed [31:0] c_r [4];
  logic signed [AW-1:0] acc_nxt [4];
  logic signed [AW-1:0] acc_r   [4];

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r <= MAT_RST;
    end else if (cfg_if.valid && cfg_if.index < hpt_pkg::CFG_IDX_W'(hpt_pkg::NUM_REGS)) begin
      mat_r[cfg_if.index[hpt_pkg::REG_SEL_W-1:0]] <= cfg_if.data;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        m[r][c] = (c % 2 == 1) ? mat_r[2 * r + (c >> 1)][63:32]
                               : mat_r[2 * r + (c >> 1)][31:0];
      end
    end
    vec[0] = in_if.x_in;
    vec[1] = in_if.y_in;
    vec[2] = in_if.mode ? '0 : in_if.z_in;
  end

  assign en          = !s2_v_r || !q_full;
  assign in_if.ready = en;
  assign push        = s2_v_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_if.valid;
      s2_v_r <= s1_v_r;
    end
  end

  always_comb begin
    logic signed [SW-1:0] sum;
    for (int r = 0; r < 4; r++) begin
      sum = SW'(p_r[r][0]) + SW'(p_r[r][1]) + SW'(p_r[r][2]);
      sum = (sum >>> FRAC_BITS) + SW'(c_r[r]);
      acc_nxt[r] = AW'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_point_r <= in_if.mode;
      s2_point_r <= s1_point_r;
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < 3; k++) begin
          p_r[r][k] <= m[r][k] * vec[k];
        end
        c_r[r]   <= m[r][3];
        acc_r[r] <= acc_nxt[r];
      end
    end
  end

  always_comb begin
    item.point  = s2_point_r;
    item.w_zero = (acc_r[3] == '0);
    for (int r = 0; r < 4; r++) begin
      item.acc[r] = acc_r[r];
    end
  end

endmodule

@@ hw/rtl/hpt_back.sv @@
// Back part: perspective divide of x, y and z by w, saturation and output register.
`timescale 1ns / 1ps

module hpt_back #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hpt_pkg::q_stat_t   stat,
  output logic               pop,
  input  hpt_pkg::hpt_item_t item,
  hpt_out_if.source          out_if
);

  localparam int AW  = hpt_pkg::ACC_W;
  localparam int QW  = hpt_pkg::COORD_W;
  localparam int LAT = QW + 1;

  logic          en;
  logic          b0_v_r;
  hpt_pkg::side_t b0_side_r;
  logic [AW-1:0] nx_r [3];
  logic [AW-1:0] nw_r;

  logic [LAT-1:0]  vld_r;
  hpt_pkg::side_t  side_r [LAT];

  logic [QW-1:0] q   [3];
  logic          ovf [3];
  logic [QW-1:0] res [3];
  logic [2:0]    sat;

  logic              out_v_r;
  logic [QW-1:0]     x_r, y_r, z_r;
  logic              wz_r, sat_r;

  assign en  = !out_v_r || out_if.ready;
  assign pop = en && !stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r  <= 1'b0;
      vld_r   <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      b0_v_r  <= pop;
      vld_r   <= {vld_r[LAT-2:0], b0_v_r};
      out_v_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0_side_r.point  <= item.point;
      b0_side_r.w_zero <= item.w_zero;
      for (int i = 0; i < 3; i++) begin
        b0_side_r.neg[i] <= item.acc[i][AW-1] ^ item.acc[3][AW-1];
        nx_r[i] <= item.acc[i][AW-1] ? AW'(0) - item.acc[i] : item.acc[i];
      end
      nw_r <= item.acc[3][AW-1] ? AW'(0) - item.acc[3] : item.acc[3];
      side_r[0] <= b0_side_r;
      for (int s = 1; s < LAT; s++) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic [QW-1:0] lim;
    logic [QW-1:0] qf;

    hpt_div_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk (clk),
      .en  (en),
      .nx  (nx_r[i]),
      .nw  (nw_r),
      .q   (q[i]),
      .ovf (ovf[i])
    );

    assign lim    = side_r[LAT-1].neg[i] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    assign sat[i] = ovf[i] || (q[i] > lim);
    assign qf     = sat[i] ? lim : q[i];
    assign res[i] = side_r[LAT-1].neg[i] ? QW'(0) - qf : qf;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wz_r <= side_r[LAT-1].w_zero;
      if (side_r[LAT-1].w_zero) begin
        x_r   <= '0;
        y_r   <= '0;
        z_r   <= '0;
        sat_r <= 1'b0;
      end else begin
        x_r   <= res[0];
        y_r   <= res[1];
        z_r   <= side_r[LAT-1].point ? '0 : res[2];
        sat_r <= sat[0] || sat[1] || (!side_r[LAT-1].point && sat[2]);
      end
    end
  end

  assign out_if.valid     = out_v_r;
  assign out_if.x_out     = x_r;
  assign out_if.y_out     = y_r;
  assign out_if.z_out     = z_r;
  assign out_if.w_zero    = wz_r;
  assign out_if.saturated = sat_r;

endmodule

@@ hw/rtl/homogeneous_point_transform_unit.sv @@
// Top level of the homogeneous 4x4 point transform unit with perspective divide.
//
// The in_if channel takes one vertex per item: mode, x_in, y_in and z_in in
// signed fixed point. The out_if channel returns one item per vertex: the
// quotients x_out, y_out and z_out, plus the w_zero and saturated flags.
// The cfg_if channel writes one 64-bit matrix register per item and is
// always ready; the user must see that registers are written only while
// the unit is idle, as the unit itself does not enforce this. An accepted
// vertex passes two multiply and sum stages, the queue, one sign stage, 33
// divider stages and the output register on its way to out_if. The divide
// runs as a 32-stage pipeline of one quotient bit per stage in each of
// three lanes, so a new vertex is taken every cycle while the queue is not
// full. When the receiver stalls, the back part holds while the front keeps
// filling the queue; in_if.ready falls once the queue is full. Reset clears
// all valid state and loads the identity matrix.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module homogeneous_point_transform_unit #(
  parameter int FRAC_BITS  = hpt_pkg::FRAC_BITS,
  parameter int FIFO_DEPTH = hpt_pkg::FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  hpt_in_if.sink    in_if,
  hpt_out_if.source out_if,
  hpt_cfg_if.sink   cfg_if
);

  logic               push;
  logic               pop;
  hpt_pkg::hpt_item_t f_item;
  hpt_pkg::hpt_item_t b_item;
  hpt_pkg::q_stat_t   q_stat;

  hpt_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .cfg_if (cfg_if),
    .q_full (q_stat.full),
    .push   (push),
    .item   (f_item)
  );

  hpt_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (f_item),
    .pop   (pop),
    .rdata (b_item),
    .stat  (q_stat)
  );

  hpt_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .stat   (q_stat),
    .pop    (pop),
    .item   (b_item),
    .out_if (out_if)
  );

  `HPT_ASSERT_IMPL(a_wzero_clears, out_if.valid && out_if.w_zero, out_if.x_out == 0 && out_if.y_out == 0 && out_if.z_out == 0 && !out_if.saturated, "w_zero item carries nonzero data")
  `HPT_ASSERT_IMPL(a_stall_cause, !in_if.ready, q_stat.full, "intake stalled without a full queue")
  `HPT_ASSERT_NEVER(a_pop_push_bounds, (pop && q_stat.empty) || (push && q_stat.full), "queue overrun or underrun")

endmodule
